@@ design/bee_pkg.sv @@
// ----------------------------------------------------------------------------
// bee_pkg: shared types and constants of the byte entropy estimator
// Holds the sequencer state type, the log unit status group and fixed-point
// constants.
// ----------------------------------------------------------------------------
package bee_pkg;

  localparam int BIN_COUNT = 256;
  localparam int BIN_AW    = 8;
  localparam int LOG_FRAC  = 16;
  localparam int MANT_W    = 31;

  localparam logic [15:0] THRESH_RESET = 16'd31949;
  localparam logic [16:0] ENT_MAX_Q12  = 17'd32768;
  localparam logic [16:0] ONE_Q12      = 17'd4096;
  localparam logic [16:0] HALF_Q12     = 17'd2048;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_LOGN,
    ST_WAITLOG,
    ST_MUL,
    ST_ACC,
    ST_BRD,
    ST_BCHK,
    ST_DIVSET,
    ST_DIV,
    ST_FIN
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } log_stat_t;

endpackage

@@ design/byte_entropy_estimator_top.sv @@
// ----------------------------------------------------------------------------
// byte_entropy_estimator_top: Shannon entropy of a block of bytes
// Builds a 256-bin histogram of the incoming bytes and, on the last byte of
// a block, reports the entropy in Q4.12 bits per byte with a threshold flag
// and a confidence figure.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                      | Contents
//  --------+----------------------------+-----------------------------------
//  input   | in_tvalid/in_tready        | tdata[7:0] data byte, tlast = end
//  result  | out_tvalid/out_tready      | tdata entropy/confidence/count,
//          |                            | tuser above-threshold flag
//  config  | cfg_valid/cfg_ready        | cfg_data = entropy threshold Q4.12
//
// A byte that is not the last of its block takes one histogram read and one
// read-modify-write through the bin memory port. A byte past the block size
// is dropped in its accept cycle. The last byte adds the evaluation, bounded
// by the shared log2 unit: a log2 per nonzero bin, a read and check per
// empty bin, a log2 for N, then a setup step, 16 divide steps and a step
// to load the result.
// After reset the block sweeps the bin memory to zero, during which no input
// byte is accepted; the control registers are reset synchronously with
// rst_n low. A finished result waits in the output register, and a new block
// can be taken meanwhile; only the next result stalls until it is taken.
// ----------------------------------------------------------------------------
module byte_entropy_estimator_top #(
  parameter int MAX_BLOCK_BYTES = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input request: [7:0] data_byte.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  // Result: [15:0] entropy_value, [28:16] confidence, [42:29] byte_count.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  // Result flags: [0] above_threshold.
  output logic        out_tuser,
  // Threshold register write.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  // Count width holds the block size itself; the log result is k and a
  // 16-bit fraction; a product c*log2(c) and the sums fit in SW bits.
  localparam int CW  = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int LW  = $clog2(CW) + bee_pkg::LOG_FRAC;
  localparam int SW  = CW + LW;
  localparam int RW  = SW + 1;
  localparam int DW  = CW + 4;
  localparam int QW  = $clog2(CW * 4096 + 2);
  localparam int QIW = $clog2(QW);

  bee_pkg::seq_state_t state_r, state_nxt;

  logic [CW-1:0]             bytes_seen_r, bytes_seen_nxt;
  logic [bee_pkg::BIN_AW-1:0] idx_r, idx_nxt;
  logic                      last_r, last_nxt;
  logic                      phase_n_r, phase_n_nxt;
  logic [CW-1:0]             cur_r, cur_nxt;
  logic [SW-1:0]             prod_r, prod_nxt;
  logic [SW-1:0]             total_r, total_nxt;
  logic [SW-1:0]             sum_r, sum_nxt;
  logic [RW-1:0]             rem_r, rem_nxt;
  logic [DW-1:0]             dvs_r, dvs_nxt;
  logic [QIW-1:0]            qi_r, qi_nxt;
  logic [QW-1:0]             q_r, q_nxt;
  logic [15:0]               thr_r;

  logic                      out_valid_r, out_valid_nxt;
  logic [15:0]               out_ent_r, out_ent_nxt;
  logic                      out_above_r, out_above_nxt;
  logic [12:0]               out_conf_r, out_conf_nxt;
  logic [13:0]               out_cnt_r, out_cnt_nxt;

  logic                      ram_we;
  logic [bee_pkg::BIN_AW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0]             ram_wdata, ram_rdata;

  logic                      log_start;
  logic [CW-1:0]             log_x;
  bee_pkg::log_stat_t        log_stat;
  logic [LW-1:0]             log_res;

  logic                      in_acc;
  logic                      sat;
  logic                      last_bin;
  logic [RW-1:0]             dvs_sh;
  logic [16:0]               ent_q12;
  logic [16:0]               thr_ext;
  logic [16:0]               conf_raw;
  logic                      above;
  logic                      out_free;

  assign in_tready = (state_r == bee_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign sat       = (bytes_seen_r >= CW'(MAX_BLOCK_BYTES));
  assign last_bin  = (idx_r == bee_pkg::BIN_AW'(bee_pkg::BIN_COUNT - 1));
  assign dvs_sh    = RW'(dvs_r) << qi_r;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // Entropy clamps at 8.0; confidence is half the excess plus one half,
  // capped at one.
  assign ent_q12  = (17'(q_r) > bee_pkg::ENT_MAX_Q12) ? bee_pkg::ENT_MAX_Q12 : 17'(q_r);
  assign thr_ext  = 17'(thr_r);
  assign above    = ent_q12 > thr_ext;
  assign conf_raw = ((ent_q12 - thr_ext) >> 1) + bee_pkg::HALF_Q12;

  bee_ram #(
    .WIDTH(CW),
    .DEPTH(bee_pkg::BIN_COUNT)
  ) u_bins (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bee_log2 #(
    .XW(CW)
  ) u_log2 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_start),
    .x     (log_x),
    .stat  (log_stat),
    .result(log_res)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bee_pkg::ST_CLEAR: begin
        if (last_bin) begin
          state_nxt = bee_pkg::ST_IDLE;
        end
      end
      bee_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!sat) begin
            state_nxt = bee_pkg::ST_UPD;
          end else if (in_tlast) begin
            state_nxt = bee_pkg::ST_LOGN;
          end
        end
      end
      bee_pkg::ST_UPD: begin
        state_nxt = last_r ? bee_pkg::ST_LOGN : bee_pkg::ST_IDLE;
      end
      bee_pkg::ST_LOGN:    state_nxt = bee_pkg::ST_WAITLOG;
      bee_pkg::ST_WAITLOG: begin
        if (log_stat.done) begin
          state_nxt = bee_pkg::ST_MUL;
        end
      end
      bee_pkg::ST_MUL: state_nxt = bee_pkg::ST_ACC;
      bee_pkg::ST_ACC: begin
        if (phase_n_r) begin
          state_nxt = bee_pkg::ST_BRD;
        end else begin
          state_nxt = last_bin ? bee_pkg::ST_DIVSET : bee_pkg::ST_BRD;
        end
      end
      bee_pkg::ST_BRD:  state_nxt = bee_pkg::ST_BCHK;
      bee_pkg::ST_BCHK: begin
        if (ram_rdata != '0) begin
          state_nxt = bee_pkg::ST_WAITLOG;
        end else if (last_bin) begin
          state_nxt = bee_pkg::ST_DIVSET;
        end else begin
          state_nxt = bee_pkg::ST_BRD;
        end
      end
      bee_pkg::ST_DIVSET: state_nxt = bee_pkg::ST_DIV;
      bee_pkg::ST_DIV: begin
        if (qi_r == '0) begin
          state_nxt = bee_pkg::ST_FIN;
        end
      end
      bee_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = bee_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bee_pkg::ST_CLEAR;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    idx_nxt        = idx_r;
    last_nxt       = last_r;
    phase_n_nxt    = phase_n_r;
    cur_nxt        = cur_r;
    prod_nxt       = prod_r;
    total_nxt      = total_r;
    sum_nxt        = sum_r;
    rem_nxt        = rem_r;
    dvs_nxt        = dvs_r;
    qi_nxt         = qi_r;
    q_nxt          = q_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_ent_nxt    = out_ent_r;
    out_above_nxt  = out_above_r;
    out_conf_nxt   = out_conf_r;
    out_cnt_nxt    = out_cnt_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = '0;
    ram_raddr      = idx_r;
    log_start      = 1'b0;
    log_x          = cur_r;

    case (state_r)
      bee_pkg::ST_CLEAR: begin
        ram_we  = 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      bee_pkg::ST_IDLE: begin
        // The bin of the arriving byte is read now and updated next cycle.
        ram_raddr = in_tdata;
        if (in_acc) begin
          cur_nxt  = CW'(in_tdata);
          last_nxt = in_tlast;
        end
      end
      bee_pkg::ST_UPD: begin
        ram_we         = 1'b1;
        ram_waddr      = cur_r[bee_pkg::BIN_AW-1:0];
        ram_wdata      = ram_rdata + 1'b1;
        bytes_seen_nxt = bytes_seen_r + 1'b1;
      end
      bee_pkg::ST_LOGN: begin
        log_start   = 1'b1;
        log_x       = bytes_seen_r;
        cur_nxt     = bytes_seen_r;
        phase_n_nxt = 1'b1;
        sum_nxt     = '0;
      end
      bee_pkg::ST_MUL: begin
        prod_nxt = SW'(cur_r) * SW'(log_res);
      end
      bee_pkg::ST_ACC: begin
        if (phase_n_r) begin
          total_nxt = prod_r;
          idx_nxt   = '0;
        end else begin
          sum_nxt = sum_r + prod_r;
          idx_nxt = idx_r + 1'b1;
        end
      end
      bee_pkg::ST_BCHK: begin
        // Each bin is cleared as it is consumed.
        ram_we = 1'b1;
        if (ram_rdata != '0) begin
          log_start   = 1'b1;
          log_x       = ram_rdata;
          cur_nxt     = ram_rdata;
          phase_n_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      bee_pkg::ST_DIVSET: begin
        rem_nxt = (total_r > sum_r) ? RW'(total_r - sum_r) : '0;
        rem_nxt = rem_nxt + RW'({bytes_seen_r, 3'b000});
        dvs_nxt = {bytes_seen_r, 4'b0000};
        qi_nxt  = QIW'(QW - 1);
        q_nxt   = '0;
      end
      bee_pkg::ST_DIV: begin
        // One restoring quotient bit per cycle, most significant first.
        if (rem_r >= dvs_sh) begin
          rem_nxt     = rem_r - dvs_sh;
          q_nxt[qi_r] = 1'b1;
        end
        qi_nxt = qi_r - 1'b1;
      end
      bee_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_ent_nxt    = ent_q12[15:0];
          out_above_nxt  = above;
          out_conf_nxt   = !above ? 13'd0 :
                           (conf_raw > bee_pkg::ONE_Q12) ? bee_pkg::ONE_Q12[12:0] :
                           conf_raw[12:0];
          out_cnt_nxt    = 14'(bytes_seen_r);
          bytes_seen_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bee_pkg::ST_CLEAR;
      bytes_seen_r <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
      thr_r        <= bee_pkg::THRESH_RESET;
      phase_n_r    <= 1'b0;
      last_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      bytes_seen_r <= bytes_seen_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
      phase_n_r    <= phase_n_nxt;
      last_r       <= last_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
    end
    cur_r       <= cur_nxt;
    prod_r      <= prod_nxt;
    total_r     <= total_nxt;
    sum_r       <= sum_nxt;
    rem_r       <= rem_nxt;
    dvs_r       <= dvs_nxt;
    qi_r        <= qi_nxt;
    q_r         <= q_nxt;
    out_ent_r   <= out_ent_nxt;
    out_above_r <= out_above_nxt;
    out_conf_r  <= out_conf_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_cnt_r, out_conf_r, out_ent_r};
  assign out_tuser  = out_above_r;

  // The byte count never passes the block size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_seen_r <= CW'(MAX_BLOCK_BYTES))
    else $error("byte count beyond block size");

  // The log unit is only started when it is free.
  a_log_free: assert property (@(posedge clk) disable iff (!rst_n)
    log_start |-> !log_stat.busy)
    else $error("log unit restarted while busy");

  // A result below the threshold carries no confidence, and confidence
  // never exceeds one.
  a_conf_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_conf_r <= bee_pkg::ONE_Q12[12:0]) &&
                    (out_above_r || (out_conf_r == 13'd0)))
    else $error("confidence out of range");

  // A new result is loaded only into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bee_pkg::ST_FIN) && out_valid_r && !out_tready |=>
      (state_r == bee_pkg::ST_FIN))
    else $error("result stage left while output stalled");

endmodule

@@ design/bee_ram.sv @@
// ----------------------------------------------------------------------------
// bee_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bee_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/bee_log2.sv @@
// ----------------------------------------------------------------------------
// bee_log2: iterative base-2 logarithm
// Returns log2(x) in Q.16 by normalizing x and squaring the mantissa once
// per cycle, one fraction bit per step.
// ----------------------------------------------------------------------------
module bee_log2 #(
  parameter int XW = 14
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [XW-1:0]                      x,
  output bee_pkg::log_stat_t                 stat,
  output logic [$clog2(XW)+bee_pkg::LOG_FRAC-1:0] result
);

  localparam int KW = $clog2(XW);
  localparam int MW = bee_pkg::MANT_W;

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [3:0]                  step_r, step_nxt;
  logic [MW-1:0]               m_r, m_nxt;
  logic [bee_pkg::LOG_FRAC-1:0] frac_r, frac_nxt;
  logic [KW-1:0]               k_r, k_nxt;
  logic [KW-1:0]               k_enc;
  logic [2*MW-1:0]             sq;
  logic [MW:0]                 sq_top;

  // Highest set bit of the operand.
  always_comb begin
    k_enc = '0;
    for (int j = 0; j < XW; j++) begin
      if (x[j]) begin
        k_enc = KW'(j);
      end
    end
  end

  assign sq     = m_r * m_r;
  assign sq_top = sq[2*MW-1:MW-1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    m_nxt    = m_r;
    frac_nxt = frac_r;
    k_nxt    = k_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      k_nxt    = k_enc;
      frac_nxt = '0;
      m_nxt    = MW'(x) << (5'(MW - 1) - 5'(k_enc));
    end else if (busy_r) begin
      // A squared mantissa of two or more yields a one bit and is halved.
      if (sq_top[MW]) begin
        m_nxt    = sq_top[MW:1];
        frac_nxt = {frac_r[bee_pkg::LOG_FRAC-2:0], 1'b1};
      end else begin
        m_nxt    = sq_top[MW-1:0];
        frac_nxt = {frac_r[bee_pkg::LOG_FRAC-2:0], 1'b0};
      end
      step_nxt = step_r + 4'd1;
      if (step_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    m_r    <= m_nxt;
    frac_r <= frac_nxt;
    k_r    <= k_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = {k_r, frac_r};

endmodule
